// ----- sv/kwpm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwpm_pkg
// Shared widths, register indexes and controller-to-datapath command types
// for the K-weighted power meter.
// ----------------------------------------------------------------------------
package kwpm_pkg;

    // Fixed-point widths
    localparam int SIG_W   = 40;  // filter signals, Q8.32
    localparam int COEF_W  = 32;  // coefficients, Q4.28
    localparam int HALF_W  = 20;  // operand split for the shared multiplier
    localparam int MUL_B_W = HALF_W + 1;
    localparam int PROD_W  = COEF_W + MUL_B_W;
    localparam int ACC_W   = 81;  // holds a full coefficient product or a square
    localparam int CM_LSB  = 28;  // coefficient product scaling
    localparam int CM_W    = 44;
    localparam int SQ_LSB  = 24;  // square scaling to 40 fraction bits
    localparam int SQ_W    = 55;
    localparam int SUM_W   = 46;  // pre-saturation sum of filter terms
    localparam int PWR_W   = 63;  // power sum, Q23.40
    localparam int SKIP_W  = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SHELF_B0    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF_B1    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF_B2    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF_A1    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHELF_A2    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_A1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_A2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP        = 4'd7;

    // Micro-sequence length per sample pair
    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 21;

    typedef struct packed {
        logic signed [COEF_W-1:0] shelf_b0;
        logic signed [COEF_W-1:0] shelf_b1;
        logic signed [COEF_W-1:0] shelf_b2;
        logic signed [COEF_W-1:0] shelf_a1;
        logic signed [COEF_W-1:0] shelf_a2;
        logic signed [COEF_W-1:0] hp_a1;
        logic signed [COEF_W-1:0] hp_a2;
    } coef_set_t;

    // Multiplier A operand
    typedef enum logic [3:0] {
        MA_SHELF_B0,
        MA_SHELF_B1,
        MA_SHELF_B2,
        MA_SHELF_A1,
        MA_SHELF_A2,
        MA_HP_A1,
        MA_HP_A2,
        MA_MAG_LO,
        MA_MAG_HI
    } mul_a_t;

    // Multiplier B operand (half picked separately)
    typedef enum logic [1:0] {
        MB_X,
        MB_Y,
        MB_U,
        MB_MAG
    } mul_b_t;

    typedef enum logic [2:0] {
        AC_HOLD,
        AC_LOAD_RC,    // coefficient rounding + product
        AC_LOAD_RS,    // square rounding + product
        AC_ADD_SH20,
        AC_ADD_SH21,
        AC_ADD_SH40
    } acc_op_t;

    typedef enum logic [2:0] {
        SO_HOLD,
        SO_CM_SD1,     // cm + shelf delay one
        SO_CM_SD2,     // cm + shelf delay two
        SO_CM,
        SO_SUB_CM,
        SO_HD2_M2Y,    // highpass delay two - 2y
        SO_Y_SUB_CM
    } sum_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_Y,
        WB_SD1,
        WB_SD2,
        WB_U,
        WB_HD1,
        WB_HD2
    } wb_t;

    typedef struct packed {
        mul_a_t  a_sel;
        mul_b_t  b_sel;
        logic    hi;
        acc_op_t acc_op;
        sum_op_t sum_op;
        wb_t     wb;
    } lane_cmd_t;

    typedef struct packed {
        lane_cmd_t lane;
        logic      load;       // take a sample pair
        logic      power_add;  // fold both squares into the sum, bump index
        logic      out_load;   // capture the result register
    } dp_cmd_t;

    localparam lane_cmd_t LANE_NOP = '{
        a_sel:  MA_SHELF_B0,
        b_sel:  MB_X,
        hi:     1'b0,
        acc_op: AC_HOLD,
        sum_op: SO_HOLD,
        wb:     WB_NONE
    };

endpackage

// ----- sv/kwpm_lane.sv -----
// ----------------------------------------------------------------------------
// kwpm_lane
// One channel: biquad delay state, shared 32x21 multiplier, product
// accumulator and a sum register with 40-bit saturation on write-back.
// ----------------------------------------------------------------------------
module kwpm_lane
    import kwpm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic                    clear,
    input  logic signed [SIG_W-1:0] x_in,
    input  coef_set_t               coef,
    input  lane_cmd_t               cmd,
    output logic        [SQ_W-1:0]  square
);

    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_CM  = ACC_W'(1) <<< (CM_LSB - 1);
    localparam logic signed [ACC_W-1:0] RND_SQ  = ACC_W'(1) <<< (SQ_LSB - 1);

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(SIG_MAX);
        lo_lim = SUM_W'(SIG_MIN);
        if (v > hi_lim) begin
            return SIG_MAX;
        end else if (v < lo_lim) begin
            return SIG_MIN;
        end
        return SIG_W'(v);
    endfunction

    logic signed [SIG_W-1:0]   x_reg, y_reg, u_reg;
    logic signed [SIG_W-1:0]   sd1_reg, sd2_reg, hd1_reg, hd2_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, prod_ext;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [CM_W-1:0]    cm;
    logic        [SIG_W-1:0]   mag;
    logic signed [SIG_W-1:0]   opnd;
    logic signed [COEF_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [SIG_W-1:0]   sum_sat, u_sat;

    assign mag = u_reg[SIG_W-1] ? SIG_W'(-u_reg) : u_reg;

    always_comb begin
        case (cmd.a_sel)
            MA_SHELF_B0: mul_a = coef.shelf_b0;
            MA_SHELF_B1: mul_a = coef.shelf_b1;
            MA_SHELF_B2: mul_a = coef.shelf_b2;
            MA_SHELF_A1: mul_a = coef.shelf_a1;
            MA_SHELF_A2: mul_a = coef.shelf_a2;
            MA_HP_A1:    mul_a = coef.hp_a1;
            MA_HP_A2:    mul_a = coef.hp_a2;
            MA_MAG_LO:   mul_a = $signed({{(COEF_W-HALF_W){1'b0}}, mag[HALF_W-1:0]});
            MA_MAG_HI:   mul_a = $signed({{(COEF_W-HALF_W){1'b0}}, mag[SIG_W-1:HALF_W]});
            default:     mul_a = '0;
        endcase
    end

    always_comb begin
        case (cmd.b_sel)
            MB_X:    opnd = x_reg;
            MB_Y:    opnd = y_reg;
            MB_U:    opnd = u_reg;
            default: opnd = $signed(mag);
        endcase
        if (cmd.b_sel == MB_MAG) begin
            mul_b = cmd.hi ? $signed({1'b0, mag[SIG_W-1:HALF_W]})
                           : $signed({1'b0, mag[HALF_W-1:0]});
        end else begin
            // high half keeps the sign, low half is unsigned
            mul_b = cmd.hi ? $signed({opnd[SIG_W-1], opnd[SIG_W-1:HALF_W]})
                           : $signed({1'b0, opnd[HALF_W-1:0]});
        end
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb begin
        case (cmd.acc_op)
            AC_LOAD_RC:  acc_next = RND_CM + prod_ext;
            AC_LOAD_RS:  acc_next = RND_SQ + prod_ext;
            AC_ADD_SH20: acc_next = acc_reg + (prod_ext <<< 20);
            AC_ADD_SH21: acc_next = acc_reg + (prod_ext <<< 21);
            AC_ADD_SH40: acc_next = acc_reg + (prod_ext <<< 40);
            default:     acc_next = acc_reg;
        endcase
    end

    assign cm     = $signed(acc_reg[CM_LSB+CM_W-1:CM_LSB]);
    assign square = acc_reg[SQ_LSB+SQ_W-1:SQ_LSB];

    always_comb begin
        case (cmd.sum_op)
            SO_CM_SD1:   sum_next = SUM_W'(cm) + SUM_W'(sd1_reg);
            SO_CM_SD2:   sum_next = SUM_W'(cm) + SUM_W'(sd2_reg);
            SO_CM:       sum_next = SUM_W'(cm);
            SO_SUB_CM:   sum_next = sum_reg - SUM_W'(cm);
            SO_HD2_M2Y:  sum_next = SUM_W'(hd2_reg) - (SUM_W'(y_reg) <<< 1);
            SO_Y_SUB_CM: sum_next = SUM_W'(y_reg) - SUM_W'(cm);
            default:     sum_next = sum_reg;
        endcase
    end

    assign sum_sat = sat_sig(sum_reg);
    assign u_sat   = sat_sig(SUM_W'(y_reg) + SUM_W'(hd1_reg));

    // datapath payload
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        if (load) begin
            x_reg <= x_in;
        end
        if (cmd.wb == WB_Y) begin
            y_reg <= sum_sat;
        end
        if (cmd.wb == WB_U) begin
            u_reg <= u_sat;
        end
    end

    // filter delay state
    always_ff @(posedge aclk) begin
        if (!aresetn || (load && clear)) begin
            sd1_reg <= '0;
            sd2_reg <= '0;
            hd1_reg <= '0;
            hd2_reg <= '0;
        end else begin
            case (cmd.wb)
                WB_SD1:  sd1_reg <= sum_sat;
                WB_SD2:  sd2_reg <= sum_sat;
                WB_HD1:  hd1_reg <= sum_sat;
                WB_HD2:  hd2_reg <= sum_sat;
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/kwpm_datapath.sv -----
// ----------------------------------------------------------------------------
// kwpm_datapath
// Configuration registers, two filter lanes, sample index, saturating
// power sum and the result register.
// ----------------------------------------------------------------------------
module kwpm_datapath
    import kwpm_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int INDEX_BITS  = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0]   cfg_index,
    input  logic        [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          first_sample,
    input  dp_cmd_t                       cmd,
    output logic        [PWR_W-1:0]       power_sum,
    output logic                          saturated
);

    localparam int XSHIFT = 33 - SAMPLE_BITS;
    localparam int CMP_W  = (INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W;
    localparam int TOT_W  = PWR_W + 2;
    localparam logic [PWR_W-1:0]      PWR_MAX = '1;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    coef_set_t               coef_reg;
    logic [SKIP_W-1:0]       skip_reg;
    logic [INDEX_BITS-1:0]   index_reg;
    logic [PWR_W-1:0]        pwr_reg;
    logic                    clip_reg;
    logic [PWR_W-1:0]        power_sum_reg;
    logic                    saturated_reg;
    logic signed [SIG_W-1:0] x_left, x_right;
    logic [SQ_W-1:0]         sq_left, sq_right;
    logic [TOT_W-1:0]        pwr_total;
    logic                    index_ge_skip;

    // Q1.(SAMPLE_BITS-1) to Q8.32
    assign x_left  = SIG_W'(left_sample) <<< XSHIFT;
    assign x_right = SIG_W'(right_sample) <<< XSHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            skip_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SHELF_B0:    coef_reg.shelf_b0 <= $signed(cfg_wdata);
                REG_SHELF_B1:    coef_reg.shelf_b1 <= $signed(cfg_wdata);
                REG_SHELF_B2:    coef_reg.shelf_b2 <= $signed(cfg_wdata);
                REG_SHELF_A1:    coef_reg.shelf_a1 <= $signed(cfg_wdata);
                REG_SHELF_A2:    coef_reg.shelf_a2 <= $signed(cfg_wdata);
                REG_HIGHPASS_A1: coef_reg.hp_a1    <= $signed(cfg_wdata);
                REG_HIGHPASS_A2: coef_reg.hp_a2    <= $signed(cfg_wdata);
                REG_SKIP:        skip_reg          <= cfg_wdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    kwpm_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.load),
        .clear   (first_sample),
        .x_in    (x_left),
        .coef    (coef_reg),
        .cmd     (cmd.lane),
        .square  (sq_left)
    );

    kwpm_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cmd.load),
        .clear   (first_sample),
        .x_in    (x_right),
        .coef    (coef_reg),
        .cmd     (cmd.lane),
        .square  (sq_right)
    );

    assign index_ge_skip = CMP_W'(index_reg) >= CMP_W'(skip_reg);
    // both squares at once: saturates exactly when either sequential add would
    assign pwr_total = TOT_W'(pwr_reg) + TOT_W'(sq_left) + TOT_W'(sq_right);

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.load && first_sample)) begin
            index_reg <= '0;
            pwr_reg   <= '0;
            clip_reg  <= 1'b0;
        end else if (cmd.power_add) begin
            if (index_ge_skip) begin
                if (pwr_total > TOT_W'(PWR_MAX)) begin
                    pwr_reg  <= PWR_MAX;
                    clip_reg <= 1'b1;
                end else begin
                    pwr_reg <= pwr_total[PWR_W-1:0];
                end
            end
            if (index_reg != IDX_MAX) begin
                index_reg <= index_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            power_sum_reg <= pwr_reg;
            saturated_reg <= clip_reg;
        end
    end

    assign power_sum = power_sum_reg;
    assign saturated = saturated_reg;

endmodule

// ----- sv/kwpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwpm_ctrl
// Sequencer: accepts a sample pair, steps the lanes through the filter and
// square micro-program, folds the power sum and hands off the result.
// ----------------------------------------------------------------------------
module kwpm_ctrl
    import kwpm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tlast,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILTER,
        ST_POWER,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;

    // Per-step lane commands. A coefficient product takes LO, HI+load, ADD20;
    // its value is in the accumulator the cycle after and feeds the sum op.
    function automatic lane_cmd_t step_cmd(input logic [STEP_W-1:0] step);
        lane_cmd_t c;
        c = LANE_NOP;
        unique case (step)
            5'd0:  begin c.a_sel = MA_SHELF_B0; c.b_sel = MB_X; end
            5'd1:  begin c.a_sel = MA_SHELF_B0; c.b_sel = MB_X; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; end
            5'd2:  begin c.a_sel = MA_SHELF_B1; c.b_sel = MB_X; c.acc_op = AC_ADD_SH20; end
            5'd3:  begin c.a_sel = MA_SHELF_B1; c.b_sel = MB_X; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; c.sum_op = SO_CM_SD1; end
            5'd4:  begin c.acc_op = AC_ADD_SH20; c.wb = WB_Y; end
            5'd5:  begin c.a_sel = MA_SHELF_A1; c.b_sel = MB_Y; c.sum_op = SO_CM_SD2; end
            5'd6:  begin c.a_sel = MA_SHELF_A1; c.b_sel = MB_Y; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; end
            5'd7:  begin c.a_sel = MA_SHELF_B2; c.b_sel = MB_X; c.acc_op = AC_ADD_SH20; end
            5'd8:  begin c.a_sel = MA_SHELF_B2; c.b_sel = MB_X; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; c.sum_op = SO_SUB_CM; end
            5'd9:  begin c.a_sel = MA_SHELF_A2; c.b_sel = MB_Y; c.acc_op = AC_ADD_SH20;
                         c.wb = WB_SD1; end
            5'd10: begin c.a_sel = MA_SHELF_A2; c.b_sel = MB_Y; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; c.sum_op = SO_CM; end
            5'd11: begin c.acc_op = AC_ADD_SH20; end
            5'd12: begin c.sum_op = SO_SUB_CM; c.wb = WB_U; end
            5'd13: begin c.a_sel = MA_HP_A1; c.b_sel = MB_U; c.wb = WB_SD2; end
            5'd14: begin c.a_sel = MA_HP_A1; c.b_sel = MB_U; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; c.sum_op = SO_HD2_M2Y; end
            5'd15: begin c.a_sel = MA_HP_A2; c.b_sel = MB_U; c.acc_op = AC_ADD_SH20; end
            5'd16: begin c.a_sel = MA_HP_A2; c.b_sel = MB_U; c.hi = 1'b1;
                         c.acc_op = AC_LOAD_RC; c.sum_op = SO_SUB_CM; end
            5'd17: begin c.acc_op = AC_ADD_SH20; c.wb = WB_HD1; end
            // square of |u|: lo*lo, hi*lo, hi*hi
            5'd18: begin c.a_sel = MA_MAG_LO; c.b_sel = MB_MAG; c.sum_op = SO_Y_SUB_CM; end
            5'd19: begin c.a_sel = MA_MAG_HI; c.b_sel = MB_MAG; c.acc_op = AC_LOAD_RS;
                         c.wb = WB_HD2; end
            5'd20: begin c.a_sel = MA_MAG_HI; c.b_sel = MB_MAG; c.hi = 1'b1;
                         c.acc_op = AC_ADD_SH21; end
            5'd21: begin c.acc_op = AC_ADD_SH40; end
            default: ;
        endcase
        return c;
    endfunction

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '{lane: LANE_NOP, load: 1'b0, power_add: 1'b0, out_load: 1'b0};

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    last_next  = s_tlast;
                    step_next  = '0;
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                cmd.lane = step_cmd(step_reg);
                if (step_reg == STEP_W'(LAST_STEP)) begin
                    state_next = ST_POWER;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_POWER: begin
                cmd.power_add = 1'b1;
                state_next    = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ----- sv/k_weighted_power_meter.sv -----
// ----------------------------------------------------------------------------
// k_weighted_power_meter
// K-weighting (high-shelf + high-pass biquads) power meter over stereo pairs.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one stereo sample pair per transaction. tuser flags the first
//   pair of a run (filter state, index and sum cleared before it), tlast the
//   final pair; after a tlast pair one result transaction leaves on m_.
//   m_ channel: the saturating Q23.40 power sum in tdata, the clip flag in
//   tuser.
//   Config: cfg_wr_en/cfg_index/cfg_wdata write coefficients and the skip
//   count; write only while the meter is idle. Indexes past seven are ignored.
// Sequence:
//   A pair occupies the meter, with s_tready low, for 22 steps on one
//   32x21 multiplier per channel: 7 coefficient products of two passes
//   each plus the three partial products of the square, then the sum.
//   m_tvalid rises once a tlast pair's sum is folded and the result loaded.
// Reset: aresetn (sync, active low) clears coefficients, skip count, filter
//   state, index and sum; no result is pending.
// Stall: a waiting result does not block input; a tlast pair finishing while
//   the previous result is still held waits until m_tready frees the slot.
// ----------------------------------------------------------------------------
module k_weighted_power_meter
    import kwpm_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    parameter  int INDEX_BITS  = 24,
    localparam int S_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((PWR_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // left_sample, right_sample, zero pad
    input  logic [0:0]            s_tuser,   // first_sample
    input  logic                  s_tlast,   // last_sample

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // power_sum, zero pad
    output logic [0:0]            m_tuser    // saturated
);

    dp_cmd_t                 dp_cmd;
    logic signed [SAMPLE_BITS-1:0] left_sample, right_sample;
    logic [PWR_W-1:0]        power_sum;
    logic                    saturated;

    assign left_sample  = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign right_sample = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

    // sequencer: handshakes and per-step commands
    kwpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd)
    );

    // filters, power sum and result register
    kwpm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .first_sample (s_tuser[0]),
        .cmd          (dp_cmd),
        .power_sum    (power_sum),
        .saturated    (saturated)
    );

    assign m_tdata = M_TDATA_W'(power_sum);
    assign m_tuser = saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // the meter is busy with an accepted pair
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again right after a transaction");

    // every accepted pair reaches the power update after the full micro-program
    a_power_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##(LAST_STEP + 2) dp_cmd.power_add)
        else $error("power update not at the expected step");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while a result is held");

    // a clipped sum sits at full scale
    a_clip_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[PWR_W-1:0] == {PWR_W{1'b1}}))
        else $error("clip flag set on a sum below full scale");

endmodule
